### design/eid_pkg.sv
package eid_pkg;

  localparam int RUN_BITS = 8;
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS = 8;

  localparam logic [RUN_BITS-1:0] RUN_MAX = '1;
  localparam logic [RUN_BITS-1:0] THRESHOLD_RESET = 8'd3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SIDE_SELECT = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RUN_THRESHOLD = 8'd1;

  typedef struct packed {
    logic                advance;
    logic                clear;
    logic                step;
    logic [RUN_BITS-1:0] threshold;
  } trk_ctrl_t;

endpackage

### design/eid_tracker.sv
module eid_tracker
  import eid_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  trk_ctrl_t ctrl,
  output logic      hit
);

  logic [RUN_BITS-1:0] advance_run;
  logic [RUN_BITS-1:0] retreat_run;
  logic                armed;

  logic [RUN_BITS-1:0] advance_run_next;
  logic [RUN_BITS-1:0] retreat_run_next;
  logic                armed_next;
  logic [RUN_BITS-1:0] advance_inc;
  logic [RUN_BITS-1:0] retreat_inc;

  assign advance_inc = (advance_run == RUN_MAX) ? RUN_MAX : advance_run + 1'b1;
  assign retreat_inc = (retreat_run == RUN_MAX) ? RUN_MAX : retreat_run + 1'b1;

  always_comb begin
    advance_run_next = advance_run;
    retreat_run_next = retreat_run;
    armed_next       = armed;
    hit              = 1'b0;
    if (ctrl.clear) begin
      advance_run_next = '0;
      retreat_run_next = '0;
      armed_next       = 1'b0;
    end else if (ctrl.step) begin
      if (ctrl.advance) begin
        advance_run_next = advance_inc;
        retreat_run_next = '0;
        armed_next       = (advance_inc > ctrl.threshold);
      end else begin
        advance_run_next = '0;
        if (armed) begin
          retreat_run_next = retreat_inc;
          hit              = (retreat_inc > ctrl.threshold);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      advance_run <= '0;
      retreat_run <= '0;
      armed       <= 1'b0;
    end else begin
      advance_run <= advance_run_next;
      retreat_run <= retreat_run_next;
      armed       <= armed_next;
    end
  end

endmodule

### design/edge_inflection_detector.sv
// channel | direction | handshake          | payload
// --------+-----------+--------------------+------------------------------------------
// in      | input     | in_valid/in_ready  | edge_position, start_of_scan, end_of_scan
// out     | output    | out_valid/out_ready| corner_found, scan_last
// cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per cycle while out is not stalled; its result appears in the cycle after acceptance.
// Trackers and found latch update on the accepting edge; result sits in an
// output register. in_ready drops only while that register is full and out
// is stalled. cfg is always ready. Synchronous reset clears all state but the
// corner_found/scan_last output register and loads the default threshold.
module edge_inflection_detector
  import eid_pkg::*;
#(
  parameter int COLUMN_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                edge_position,
  input  logic                      start_of_scan,
  input  logic                      end_of_scan,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      corner_found,
  output logic                      scan_last,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int EDGE_BITS = (COLUMN_BITS < 8) ? COLUMN_BITS : 8;

  logic                 side_select;
  logic [RUN_BITS-1:0]  run_threshold;
  logic [EDGE_BITS-1:0] previous_edge;
  logic                 found_latch;
  logic                 found_next;
  logic [EDGE_BITS-1:0] edge_col;
  logic                 accept;
  logic                 hit_strict;
  logic                 hit_loose;
  logic                 strict_adv;
  logic                 loose_adv;
  trk_ctrl_t            strict_ctrl;
  trk_ctrl_t            loose_ctrl;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign edge_col  = edge_position[EDGE_BITS-1:0];

  always_comb begin
    if (side_select) begin
      strict_adv = edge_col < previous_edge;
      loose_adv  = edge_col <= previous_edge;
    end else begin
      strict_adv = edge_col > previous_edge;
      loose_adv  = edge_col >= previous_edge;
    end
  end

  assign strict_ctrl = '{advance: strict_adv, clear: accept && start_of_scan,
                         step: accept && !start_of_scan, threshold: run_threshold};
  assign loose_ctrl  = '{advance: loose_adv, clear: accept && start_of_scan,
                         step: accept && !start_of_scan, threshold: run_threshold};

  eid_tracker u_strict (
    .clk  (clk),
    .rst  (rst),
    .ctrl (strict_ctrl),
    .hit  (hit_strict)
  );

  eid_tracker u_loose (
    .clk  (clk),
    .rst  (rst),
    .ctrl (loose_ctrl),
    .hit  (hit_loose)
  );

  assign found_next = start_of_scan ? 1'b0 : (found_latch || hit_strict || hit_loose);

  always_ff @(posedge clk) begin
    if (rst) begin
      side_select   <= 1'b0;
      run_threshold <= THRESHOLD_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SIDE_SELECT:   side_select   <= cfg_data[0];
        REG_RUN_THRESHOLD: run_threshold <= cfg_data[RUN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_edge <= '0;
      found_latch   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        previous_edge <= edge_col;
        found_latch   <= found_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      corner_found <= found_next;
      scan_last    <= end_of_scan;
    end
  end

endmodule

### bench/tb_edge_inflection_detector.sv
`timescale 1ns / 1ps

module tb_edge_inflection_detector;
  import eid_pkg::*;

  localparam int COL_BITS = 8;
  localparam int IDLE_LIMIT = 2000;
  localparam int NUM_PHASES = 9;
  localparam bit SIDE_LEFT = 1'b0;
  localparam bit SIDE_RIGHT = 1'b1;

  typedef struct packed {
    logic corner;
    logic last;
  } verdict_t;

  typedef struct packed {
    logic [7:0] col;
    logic       sos;
    logic       eos;
    logic       typed;
    verdict_t   want;
  } row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [7:0]                edge_position = '0;
  logic                      start_of_scan = 1'b0;
  logic                      end_of_scan = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      corner_found;
  logic                      scan_last;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  // typed expectation travelling with the item on the input channel
  logic     cur_typed = 1'b0;
  verdict_t cur_want = '0;

  edge_inflection_detector #(
    .COLUMN_BITS(COL_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .edge_position(edge_position),
    .start_of_scan(start_of_scan),
    .end_of_scan(end_of_scan),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .corner_found(corner_found),
    .scan_last(scan_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic                side_q;
  logic [RUN_BITS-1:0] thresh_q;
  logic [7:0]          prev_col;
  logic [RUN_BITS-1:0] adv_run [2];
  logic [RUN_BITS-1:0] ret_run [2];
  logic                trk_armed [2];
  logic                found_q;

  verdict_t verdict_q [$];
  int errors = 0;
  int idle_cycles = 0;
  int snd_idle = 18;
  int rcv_idle = 48;

  row_t directed [16] = '{
    '{8'd255, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b0}},  // before any start, vs column zero
    '{8'd0,   1'b1, 1'b0, 1'b1, '{1'b0, 1'b0}},
    '{8'd10,  1'b0, 1'b0, 1'b0, '{1'b0, 1'b0}},
    '{8'd20,  1'b0, 1'b0, 1'b0, '{1'b0, 1'b0}},
    '{8'd30,  1'b0, 1'b0, 1'b0, '{1'b0, 1'b0}},
    '{8'd40,  1'b0, 1'b0, 1'b0, '{1'b0, 1'b0}},
    '{8'd40,  1'b0, 1'b0, 1'b0, '{1'b0, 1'b0}},
    '{8'd30,  1'b0, 1'b0, 1'b0, '{1'b0, 1'b0}},
    '{8'd20,  1'b0, 1'b0, 1'b0, '{1'b0, 1'b0}},
    '{8'd10,  1'b0, 1'b0, 1'b0, '{1'b0, 1'b0}},
    '{8'd0,   1'b0, 1'b0, 1'b0, '{1'b0, 1'b0}},
    '{8'd255, 1'b0, 1'b1, 1'b0, '{1'b0, 1'b0}},
    '{8'd128, 1'b0, 1'b0, 1'b0, '{1'b0, 1'b0}},  // past end, no new start
    '{8'd0,   1'b1, 1'b1, 1'b1, '{1'b0, 1'b1}},
    '{8'd0,   1'b0, 1'b0, 1'b0, '{1'b0, 1'b0}},
    '{8'd255, 1'b1, 1'b0, 1'b1, '{1'b0, 1'b0}}
  };

  bit phase_side [NUM_PHASES] = '{SIDE_RIGHT, SIDE_LEFT, SIDE_RIGHT, SIDE_LEFT, SIDE_RIGHT,
                                  SIDE_RIGHT, SIDE_LEFT, SIDE_RIGHT, SIDE_LEFT};
  int phase_thr [NUM_PHASES] = '{0, 0, 2, 255, 254, 4, 1, 255, -1};
  int phase_budget [NUM_PHASES] = '{60, 60, 60, 1, 1, 60, 60, 1, 60};

  function automatic logic [RUN_BITS-1:0] sat_inc(logic [RUN_BITS-1:0] v);
    return (v != RUN_MAX) ? v + 1'b1 : RUN_MAX;
  endfunction

  function automatic void clear_runs();
    for (int k = 0; k < 2; k++) begin
      adv_run[k] = '0;
      ret_run[k] = '0;
      trk_armed[k] = 1'b0;
    end
    found_q = 1'b0;
  endfunction

  function automatic bit track_step(int k, bit adv);
    if (adv) begin
      trk_armed[k] = 1'b0;
      ret_run[k] = '0;
      adv_run[k] = sat_inc(adv_run[k]);
      if (adv_run[k] > thresh_q) trk_armed[k] = 1'b1;
      return 1'b0;
    end
    adv_run[k] = '0;
    if (trk_armed[k]) begin
      ret_run[k] = sat_inc(ret_run[k]);
      if (ret_run[k] > thresh_q) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic verdict_t predict_row(logic [7:0] col, bit sos, bit eos);
    logic [7:0] c;
    bit strict_adv;
    bit loose_adv;
    bit hit_s;
    bit hit_l;
    verdict_t v;
    c = col & 8'((1 << COL_BITS) - 1);
    if (sos) begin
      clear_runs();
    end else begin
      if (side_q == SIDE_LEFT) begin
        strict_adv = c > prev_col;
        loose_adv = c >= prev_col;
      end else begin
        strict_adv = c < prev_col;
        loose_adv = c <= prev_col;
      end
      hit_s = track_step(0, strict_adv);
      hit_l = track_step(1, loose_adv);
      if (hit_s || hit_l) found_q = 1'b1;
    end
    prev_col = c;
    v.corner = found_q;
    v.last = eos;
    return v;
  endfunction

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rcv_idle);
  end

  always @(posedge clk) begin : monitor
    verdict_t got;
    verdict_t want;
    verdict_t pred;
    if (rst) begin
      side_q = SIDE_LEFT;
      thresh_q = THRESHOLD_RESET;
      prev_col = '0;
      clear_runs();
      verdict_q.delete();
      idle_cycles = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.corner = corner_found;
        got.last = scan_last;
        if (verdict_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: corner_found=%b scan_last=%b", got.corner, got.last);
        end else begin
          want = verdict_q.pop_front();
          if (got.corner !== want.corner || got.last !== want.last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: corner_found exp %b got %b, scan_last exp %b got %b",
                       want.corner, got.corner, want.last, got.last);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SIDE_SELECT) side_q = cfg_data[0];
        else if (cfg_index == REG_RUN_THRESHOLD) thresh_q = cfg_data;
      end
      if (in_valid && in_ready) begin
        pred = predict_row(edge_position, start_of_scan, end_of_scan);
        verdict_q.push_back(cur_typed ? cur_want : pred);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  task automatic send_row(row_t r);
    if ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < snd_idle);
    end
    in_valid <= 1'b1;
    edge_position <= r.col;
    start_of_scan <= r.sos;
    end_of_scan <= r.eos;
    cur_typed <= r.typed;
    cur_want <= r.want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one scan: mostly advance/retreat runs around the threshold, some noise
  task automatic send_scan(bit side, int thr, inout int sent);
    row_t r;
    int pos;
    int kind;
    int nseg;
    int len;
    int dir;
    int adv_dir;
    r = '0;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      repeat ($urandom_range(1, 12)) begin
        r.col = 8'($urandom_range(0, 255));
        r.sos = ($urandom_range(0, 9) == 0);
        r.eos = ($urandom_range(0, 3) == 0);
        send_row(r);
        sent++;
      end
    end else begin
      pos = $urandom_range(0, 255);
      if (kind >= 25) begin
        r.col = 8'(pos);
        r.sos = 1'b1;
        r.eos = 1'b0;
        send_row(r);
        sent++;
      end
      adv_dir = (side == SIDE_LEFT) ? 1 : -1;
      nseg = (thr > 16) ? 2 : $urandom_range(2, 4);
      for (int s = 0; s < nseg; s++) begin
        len = (thr > 16) ? thr + $urandom_range(1, 3) : thr + $urandom_range(0, 3) - 1;
        if (len < 1) len = 1;
        if (s % 2 == 0) dir = adv_dir;
        else dir = ($urandom_range(0, 3) == 0) ? 0 : -adv_dir;
        for (int j = 0; j < len; j++) begin
          pos = pos + dir * $urandom_range(0, 3);
          if (pos < 0) pos = 0;
          if (pos > 255) pos = 255;
          r.col = 8'(pos);
          r.sos = 1'b0;
          r.eos = (s == nseg - 1) && (j == len - 1) && ($urandom_range(0, 9) != 0);
          send_row(r);
          sent++;
        end
      end
    end
  endtask

  initial begin : stimulus
    int sent;
    int thr;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_row(directed[i]);
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      if (p == 3) begin
        snd_idle = 48;
        rcv_idle = 18;
      end else if (p == 6) begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      thr = (phase_thr[p] < 0) ? $urandom_range(0, 7) : phase_thr[p];
      write_reg(REG_SIDE_SELECT, CFG_DATA_BITS'(phase_side[p]));
      write_reg(REG_RUN_THRESHOLD, CFG_DATA_BITS'(thr));
      sent = 0;
      while (sent < phase_budget[p]) send_scan(phase_side[p], thr, sent);
    end
    wait_drained();
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
design/eid_pkg.sv
design/eid_tracker.sv
design/edge_inflection_detector.sv
bench/tb_edge_inflection_detector.sv
